FILE: src/assert_macros.svh
// Assertion macros shared by the queue RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("queue assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("queue assertion failed (next cycle)");

`endif

FILE: src/fqps_pkg.sv
// Package for the identifier queue with position search: sizes, opcodes, types.
// No dependencies; imported by every other file of the block but assert_macros.svh.
`default_nettype none
package fqps_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int ID_WIDTH    = 16;

   localparam int OPCODE_W = 2;
   localparam int OUT_ID_W = 16;
   localparam int POS_W    = 6;
   localparam int OCC_W    = 7;

   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int GRP_SIZE  = 8;
   localparam int GRP_IDX_W = $clog2(GRP_SIZE);
   localparam int NUM_GRPS  = (QUEUE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
   localparam int GRP_W     = (NUM_GRPS > 1) ? $clog2(NUM_GRPS) : 1;
   localparam int PAD_W     = NUM_GRPS * GRP_SIZE;

   localparam logic [OPCODE_W-1:0] OP_PUSH = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_POP  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_FIND = 2'd2;

   // Broadcast to every cell in the row.
   typedef struct packed {
      logic                push;
      logic                shift;
      logic                find;
      logic [ID_WIDTH-1:0] id;
   } fqps_ctrl_type;

   typedef struct packed {
      logic [OUT_ID_W-1:0] popped_id;
      logic [POS_W-1:0]    position;
      logic                hit;
      logic                overflow;
      logic [OCC_W-1:0]    occupancy;
   } fqps_rsp_type;

endpackage
`default_nettype wire

FILE: src/fqps_if.sv
// Request and response channel interfaces of the identifier queue.
// Depends on fqps_pkg for field widths.
`default_nettype none
interface fqps_req_if;
   import fqps_pkg::*;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [OUT_ID_W-1:0] item_id;
   modport source (output valid, output opcode, output item_id, input ready);
   modport sink   (input valid, input opcode, input item_id, output ready);
endinterface

interface fqps_rsp_if;
   import fqps_pkg::*;
   logic                valid;
   logic                ready;
   logic [OUT_ID_W-1:0] popped_id;
   logic [POS_W-1:0]    position;
   logic                hit;
   logic                overflow;
   logic [OCC_W-1:0]    occupancy;
   modport source (output valid, output popped_id, output position, output hit,
                   output overflow, output occupancy, input ready);
   modport sink   (input valid, input popped_id, input position, input hit,
                   input overflow, input occupancy, output ready);
endinterface
`default_nettype wire

FILE: src/fqps_cell.sv
// One queue slot: holds an identifier, shifts toward the head on pop,
// compares against the search key on find. Depends on fqps_pkg.
`default_nettype none
module fqps_cell (
   input  logic                             clock,
   input  fqps_pkg::fqps_ctrl_type          ctrl_i,
   input  logic                             sel_i,
   input  logic [fqps_pkg::ID_WIDTH-1:0]    next_data_i,
   output logic [fqps_pkg::ID_WIDTH-1:0]    data_o,
   output logic                             match_o
);
   import fqps_pkg::*;

   logic [ID_WIDTH-1:0] data_ff, data_in;
   logic                match_ff, match_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl_i.shift) begin
         data_in = next_data_i;
      end else if (ctrl_i.push && sel_i) begin
         data_in = ctrl_i.id;
      end
      match_in = ctrl_i.find ? (data_ff == ctrl_i.id) : match_ff;
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data_o  = data_ff;
   assign match_o = match_ff;

endmodule
`default_nettype wire

FILE: src/fqps_group_enc.sv
// First-set-bit encoder over one group of cell match flags.
// Depends on fqps_pkg for the group size.
`default_nettype none
module fqps_group_enc (
   input  logic [fqps_pkg::GRP_SIZE-1:0]  bits_i,
   output logic                           any_o,
   output logic [fqps_pkg::GRP_IDX_W-1:0] idx_o
);
   import fqps_pkg::*;

   always_comb begin
      any_o = 1'b0;
      idx_o = '0;
      // Walk down so the lowest set bit wins.
      for (int i = GRP_SIZE - 1; i >= 0; i--) begin
         if (bits_i[i]) begin
            any_o = 1'b1;
            idx_o = GRP_IDX_W'(i);
         end
      end
   end

endmodule
`default_nettype wire

FILE: src/fqps_out_buf.sv
// Two-entry response buffer that decouples the queue from a stalled consumer.
// Depends on fqps_pkg and fqps_if.
`default_nettype none
module fqps_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en_i,
   input  fqps_pkg::fqps_rsp_type wr_data_i,
   output logic                   full_o,
   fqps_rsp_if.source             rsp_ch
);
   import fqps_pkg::*;

   fqps_rsp_type entries_ff [2];
   logic         rd_ptr_ff, rd_ptr_in;
   logic         wr_ptr_ff, wr_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         rd_en;

   assign rd_en = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      rd_ptr_in = rd_en   ? !rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = wr_en_i ? !wr_ptr_ff : wr_ptr_ff;
      cnt_in    = cnt_ff + 2'(wr_en_i) - 2'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en_i) begin
         entries_ff[wr_ptr_ff] <= wr_data_i;
      end
   end

   assign full_o           = (cnt_ff == 2'd2);
   assign rsp_ch.valid     = (cnt_ff != 2'd0);
   assign rsp_ch.popped_id = entries_ff[rd_ptr_ff].popped_id;
   assign rsp_ch.position  = entries_ff[rd_ptr_ff].position;
   assign rsp_ch.hit       = entries_ff[rd_ptr_ff].hit;
   assign rsp_ch.overflow  = entries_ff[rd_ptr_ff].overflow;
   assign rsp_ch.occupancy = entries_ff[rd_ptr_ff].occupancy;

endmodule
`default_nettype wire

FILE: src/fifo_queue_with_position_search.sv
// Identifier queue with position search, built as a row of shifting cells.
// Push, pop and no-op: one item per cycle while the response buffer has room,
// result ready in the cycle after accept. Find: cell compare, per-group encode
// and group select in turn, through the two levels of the first-match encoder.
// No new item is taken until a find completes. Reset clears occupancy, sequencer
// and response buffer; slot contents stay undefined until pushed. Depends on fqps_pkg, fqps_if and the fqps_* modules.
`default_nettype none
`include "assert_macros.svh"
module fifo_queue_with_position_search (
   input  logic       clock,
   input  logic       reset,
   fqps_req_if.sink   req_ch,
   fqps_rsp_if.source rsp_ch
);
   import fqps_pkg::*;

   // Find sequencer codes.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_GROUP = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [QUEUE_DEPTH-1:0] mask_ff, mask_in;
   logic                   grp_any_ff [NUM_GRPS];
   logic [GRP_IDX_W-1:0]   grp_idx_ff [NUM_GRPS];

   logic                   req_take;
   logic                   is_full;
   logic                   is_empty;
   logic                   full_push;
   logic                   ob_full;
   fqps_ctrl_type          ctrl;

   logic [ID_WIDTH-1:0]    cell_data [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_match;
   logic [QUEUE_DEPTH-1:0] cell_sel;
   logic [PAD_W-1:0]       match_pad;
   logic                   grp_any [NUM_GRPS];
   logic [GRP_IDX_W-1:0]   grp_idx [NUM_GRPS];

   logic                   fin_hit;
   logic [GRP_W-1:0]       fin_grp;
   logic [GRP_IDX_W-1:0]   fin_idx;

   logic                   wr_en;
   fqps_rsp_type           wr_data;

   // Take a new item only with the sequencer idle and room in the buffer, so
   // every accepted item has a slot waiting for its result.
   assign req_ch.ready = (state_ff == ST_IDLE) && !ob_full;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign is_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);

   // A push that arrives with every slot taken: drop it.
   assign full_push = req_take && (req_ch.opcode == OP_PUSH) && is_full;

   // Broadcast to the row: push lands in the first free cell, pop shifts
   // every cell one place toward the head, find latches each cell's compare.
   always_comb begin
      ctrl.push  = req_take && (req_ch.opcode == OP_PUSH) && !is_full;
      ctrl.shift = req_take && (req_ch.opcode == OP_POP) && !is_empty;
      ctrl.find  = req_take && (req_ch.opcode == OP_FIND);
      ctrl.id    = ID_WIDTH'(req_ch.item_id);
   end

   // Cell row: cell 0 is the head; the last cell refills from itself on a
   // shift, which is harmless since it is then beyond the occupancy.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [ID_WIDTH-1:0] next_data;
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_data = cell_data[i];
      end else begin : g_mid
         assign next_data = cell_data[i + 1];
      end
      assign cell_sel[i] = (count_ff == CNT_W'(i));
      assign mask_in[i]  = (CNT_W'(i) < count_ff);

      fqps_cell u_cell (
         .clock       (clock),
         .ctrl_i      (ctrl),
         .sel_i       (cell_sel[i]),
         .next_data_i (next_data),
         .data_o      (cell_data[i]),
         .match_o     (cell_match[i])
      );
   end

   // Drop compares from cells past the occupancy, pad to whole groups.
   assign match_pad = PAD_W'(cell_match & mask_ff);

   for (genvar g = 0; g < NUM_GRPS; g++) begin : g_grp
      fqps_group_enc u_enc (
         .bits_i (match_pad[g*GRP_SIZE +: GRP_SIZE]),
         .any_o  (grp_any[g]),
         .idx_o  (grp_idx[g])
      );
   end

   // Second level: lowest group with a match wins.
   always_comb begin
      fin_hit = 1'b0;
      fin_grp = '0;
      fin_idx = '0;
      for (int g = NUM_GRPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            fin_hit = 1'b1;
            fin_grp = GRP_W'(g);
            fin_idx = grp_idx_ff[g];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.shift) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  state_in = ctrl.find ? ST_GROUP : ST_IDLE;
         ST_GROUP: state_in = ST_FINAL;
         ST_FINAL: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Result: a finishing find owns the buffer write; otherwise push, pop and
   // no-op results go in the cycle they are accepted.
   always_comb begin
      wr_en             = 1'b0;
      wr_data           = '0;
      wr_data.occupancy = OCC_W'(count_in);
      priority if (state_ff == ST_FINAL) begin
         wr_en            = 1'b1;
         wr_data.hit      = fin_hit;
         wr_data.position = POS_W'({fin_grp, fin_idx});
      end else if (req_take && (req_ch.opcode != OP_FIND)) begin
         wr_en = 1'b1;
         unique case (req_ch.opcode)
            OP_PUSH: wr_data.overflow = is_full;
            OP_POP: begin
               wr_data.hit = !is_empty;
               if (!is_empty) begin
                  wr_data.popped_id = OUT_ID_W'(cell_data[0]);
               end
            end
            default: ;
         endcase
      end else begin
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Search pipeline registers: hold the occupancy mask from the find
   // accept, latch group results for the final select.
   always_ff @(posedge clock) begin
      if (ctrl.find) begin
         mask_ff <= mask_in;
      end
      if (state_ff == ST_GROUP) begin
         for (int g = 0; g < NUM_GRPS; g++) begin
            grp_any_ff[g] <= grp_any[g];
            grp_idx_ff[g] <= grp_idx[g];
         end
      end
   end

   fqps_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .wr_en_i   (wr_en),
      .wr_data_i (wr_data),
      .full_o    (ob_full),
      .rsp_ch    (rsp_ch)
   );

   // A find in flight blocks new items.
   `ASSERT_IMPL(a_busy_blocks, clock, reset, state_ff != ST_IDLE, !req_ch.ready)
   // An accepted find starts the group encode next cycle.
   `ASSERT_NEXT(a_find_starts, clock, reset, ctrl.find, state_ff == ST_GROUP)
   // A push into a full queue leaves the occupancy alone.
   `ASSERT_NEXT(a_full_push_holds, clock, reset, full_push, count_ff == $past(count_ff))
   // A result is written only when the buffer has room or is being read in the same cycle.
   `ASSERT_IMPL(a_no_buf_overrun, clock, reset, wr_en, !ob_full || rsp_ch.ready)

endmodule
`default_nettype wire
